// ===== sv/lpps_pkg.sv =====
// Shared types, constants and helper functions for the lane pure pursuit steering block.
// No dependencies; every other file in sv/ refers to this package by scoped names.
package lpps_pkg;

    localparam int CW             = 40;   // CORDIC datapath width, Q2.30 plus headroom
    localparam int TABLE_LEN      = 24;
    localparam int MAX_POINTS_DEF = 4096;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int DIV_STEPS      = 16;
    localparam int CFG_W          = 15;
    localparam int CFG_AW         = 3;
    localparam int CNT_W          = 13;

    localparam logic signed [CW-1:0] ONE_Q30  = CW'(64'sd1073741824);
    localparam logic signed [CW-1:0] KINV_Q30 = CW'(64'sd652032874);

    localparam logic [CFG_AW-1:0] REG_CENTERED = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MICRO    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_GATE2    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_GATE1    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_RATIO    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_GAIN     = 3'd5;

    localparam logic [1:0] USED_NONE = 2'd0;
    localparam logic [1:0] USED_ONE  = 2'd1;
    localparam logic [1:0] USED_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0]         used;
        logic signed [15:0] slope_l;
        logic signed [15:0] slope_r;
        logic [CNT_W-1:0]   cnt_l;
        logic [CNT_W-1:0]   cnt_r;
        logic               near_l;
        logic               near_r;
        logic               neg_b;
    } t_task;

    typedef struct packed {
        logic start;
        logic rotate;
    } t_cordic_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_PREP, S_DIV, S_ATAN1, S_SIN, S_SCALE,
        S_ATAN2, S_GAIN, S_ROUND, S_CORR, S_FIN
    } t_back_state;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] v;
        unique case (i)
            5'd0:  v = CW'(64'sd843314856);
            5'd1:  v = CW'(64'sd497837829);
            5'd2:  v = CW'(64'sd263043836);
            5'd3:  v = CW'(64'sd133525158);
            5'd4:  v = CW'(64'sd67021686);
            5'd5:  v = CW'(64'sd33543515);
            5'd6:  v = CW'(64'sd16775850);
            5'd7:  v = CW'(64'sd8388437);
            5'd8:  v = CW'(64'sd4194282);
            5'd9:  v = CW'(64'sd2097149);
            5'd10: v = CW'(64'sd1048575);
            5'd11: v = CW'(64'sd524287);
            5'd12: v = CW'(64'sd262143);
            5'd13: v = CW'(64'sd131071);
            5'd14: v = CW'(64'sd65535);
            5'd15: v = CW'(64'sd32767);
            5'd16: v = CW'(64'sd16383);
            5'd17: v = CW'(64'sd8191);
            5'd18: v = CW'(64'sd4095);
            5'd19: v = CW'(64'sd2047);
            5'd20: v = CW'(64'sd1023);
            5'd21: v = CW'(64'sd511);
            5'd22: v = CW'(64'sd255);
            5'd23: v = CW'(64'sd127);
            default: v = '0;
        endcase
        return v;
    endfunction

    // true magnitude of a 16-bit signed value
    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
        logic signed [15:0] r;
        if (v > CW'(32767))       r = 16'sh7fff;
        else if (v < -CW'(32768)) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

endpackage

// ===== sv/lpps_front.sv =====
// Front end: classify one input item into a steering task (lines used, left/right, centering).
// Depends on lpps_pkg.
module lpps_front #(
    parameter int MAX_POINTS = lpps_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_valid_a,
    input  logic signed [15:0]            i_slope_a,
    input  logic signed [15:0]            i_intercept_a,
    input  logic [lpps_pkg::CNT_W-1:0]    i_points_a,
    input  logic                          i_valid_b,
    input  logic signed [15:0]            i_slope_b,
    input  logic signed [15:0]            i_intercept_b,
    input  logic [lpps_pkg::CNT_W-1:0]    i_points_b,
    input  logic [lpps_pkg::CFG_W-1:0]    i_centered,
    output lpps_pkg::t_task               o_task
);

    function automatic logic [lpps_pkg::CNT_W-1:0] clamp(input logic [lpps_pkg::CNT_W-1:0] n);
        return (32'(n) > MAX_POINTS) ? lpps_pkg::CNT_W'(MAX_POINTS) : n;
    endfunction

    logic                       has_a, has_b, a_left;
    logic signed [15:0]         b_l, b_r, b_one;
    logic [lpps_pkg::CNT_W-1:0] n_l, n_r;

    always_comb begin
        has_a  = i_valid_a && (i_slope_a != '0);
        has_b  = i_valid_b && (i_slope_b != '0);
        a_left = i_intercept_a > i_intercept_b;
        b_l    = a_left ? i_intercept_a : i_intercept_b;
        b_r    = a_left ? i_intercept_b : i_intercept_a;
        n_l    = clamp(a_left ? i_points_a : i_points_b);
        n_r    = clamp(a_left ? i_points_b : i_points_a);
        b_one  = has_a ? i_intercept_a : i_intercept_b;

        o_task = '0;
        if (has_a && has_b) begin
            o_task.used    = lpps_pkg::USED_TWO;
            o_task.slope_l = a_left ? i_slope_a : i_slope_b;
            o_task.slope_r = a_left ? i_slope_b : i_slope_a;
            // both counts zero: weight the lines equally
            o_task.cnt_l   = (n_l == '0 && n_r == '0) ? lpps_pkg::CNT_W'(1) : n_l;
            o_task.cnt_r   = (n_l == '0 && n_r == '0) ? lpps_pkg::CNT_W'(1) : n_r;
            o_task.near_l  = lpps_pkg::mag16(b_l) < 17'(i_centered);
            o_task.near_r  = lpps_pkg::mag16(b_r) < 17'(i_centered);
        end else if (has_a || has_b) begin
            o_task.used    = lpps_pkg::USED_ONE;
            o_task.slope_l = has_a ? i_slope_a : i_slope_b;
            o_task.near_l  = lpps_pkg::mag16(b_one) < 17'(i_centered);
            o_task.neg_b   = b_one[15];
        end else begin
            o_task.used    = lpps_pkg::USED_NONE;
        end
    end

endmodule

// ===== sv/lpps_queue.sv =====
// Short task queue between front and back end.
// Depends on lpps_pkg for the task type and depth.
module lpps_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpps_pkg::t_task i_data,
    input  logic            i_pop,
    output lpps_pkg::t_task o_data,
    output logic            o_full,
    output logic            o_empty,
    output logic [$clog2(lpps_pkg::QUEUE_DEPTH+1)-1:0] o_level
);

    localparam int PW = $clog2(lpps_pkg::QUEUE_DEPTH);
    localparam int LW = $clog2(lpps_pkg::QUEUE_DEPTH+1);

    lpps_pkg::t_task r_mem [lpps_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [LW-1:0]   r_level;
    logic            do_push, do_pop;

    assign o_full  = (r_level == LW'(lpps_pkg::QUEUE_DEPTH));
    assign o_empty = (r_level == '0);
    assign o_level = r_level;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (do_push) r_wp <= (32'(r_wp) == lpps_pkg::QUEUE_DEPTH-1) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (32'(r_rp) == lpps_pkg::QUEUE_DEPTH-1) ? '0 : r_rp + 1'b1;
            r_level <= r_level + LW'(do_push) - LW'(do_pop);
        end
    end

endmodule

// ===== sv/lpps_cordic.sv =====
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on lpps_pkg for the angle table and datapath width.
module lpps_cordic #(
    parameter int CORDIC_STEPS = lpps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpps_pkg::t_cordic_cmd         i_cmd,
    input  logic signed [lpps_pkg::CW-1:0] i_x,
    input  logic signed [lpps_pkg::CW-1:0] i_y,
    input  logic signed [lpps_pkg::CW-1:0] i_z,
    output logic                          o_done,
    output logic signed [lpps_pkg::CW-1:0] o_y,
    output logic signed [lpps_pkg::CW-1:0] o_z
);

    localparam int CW = lpps_pkg::CW;

    logic                 r_busy, r_done, r_rot;
    logic [4:0]           r_i;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic signed [CW-1:0] dx, dy, t;
    logic                 pos;

    always_comb begin
        dx  = r_y >>> r_i;
        dy  = r_x >>> r_i;
        t   = lpps_pkg::atan_q30(r_i);
        // vectoring on y >= 0 and rotation on z < 0 share one direction
        pos = r_rot ? r_z[CW-1] : !r_y[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_rot <= i_cmd.rotate;
        end else if (r_busy) begin
            r_x <= pos ? r_x + dx : r_x - dx;
            r_y <= pos ? r_y - dy : r_y + dy;
            r_z <= pos ? r_z + t  : r_z - t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (32'(r_i) == CORDIC_STEPS-1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ===== sv/lpps_back.sv =====
// Back end: mean slope divider, pure pursuit via the CORDIC unit, corrections, result register.
// Depends on lpps_pkg and lpps_cordic.
module lpps_back #(
    parameter int CORDIC_STEPS = lpps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lpps_pkg::t_task            i_task,
    input  logic                       i_task_empty,
    output logic                       o_task_pop,
    input  logic [lpps_pkg::CFG_W-1:0] i_micro,
    input  logic [lpps_pkg::CFG_W-1:0] i_gate2,
    input  logic [lpps_pkg::CFG_W-1:0] i_gate1,
    input  logic [lpps_pkg::CFG_W-1:0] i_ratio,
    input  logic [lpps_pkg::CFG_W-1:0] i_gain,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic signed [15:0]         o_steer_angle,
    output logic [1:0]                 o_lines_used
);

    localparam int CW  = lpps_pkg::CW;
    localparam int DCW = $clog2(lpps_pkg::DIV_STEPS);

    lpps_pkg::t_back_state r_state, n_state;
    lpps_pkg::t_task       r_task;
    lpps_pkg::t_cordic_cmd cmd;

    logic signed [CW-1:0] c_x, c_y, c_z, c_oy, c_oz;
    logic                 c_done;

    logic signed [30:0]   r_acc;
    logic                 r_neg;
    logic [15:0]          r_den2, r_lo;
    logic [14:0]          r_rem;
    logic [DCW-1:0]       r_cnt;
    logic signed [15:0]   r_w, r_steer, r_last;
    logic signed [CW-1:0] r_alpha, r_y1;
    logic signed [33:0]   r_s;
    logic signed [32:0]   r_beta;
    logic signed [47:0]   r_p;
    logic                 r_launch;
    logic                 r_out_valid;
    logic signed [15:0]   r_out_steer;
    logic [1:0]           r_out_used;

    logic signed [30:0]   prod_r;
    logic [30:0]          acc_mag, div_n;
    logic [15:0]          trial, quot;
    logic                 out_free;
    logic signed [49:0]   prod_s;
    logic signed [47:0]   p_sh;
    logic signed [CW-1:0] corr;

    assign out_free = !r_out_valid || i_pop;

    lpps_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_x     (c_x),
        .i_y     (c_y),
        .i_z     (c_z),
        .o_done  (c_done),
        .o_y     (c_oy),
        .o_z     (c_oz)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpps_pkg::S_IDLE: begin
                if (!i_task_empty) begin
                    unique case (i_task.used)
                        lpps_pkg::USED_TWO: n_state = lpps_pkg::S_MUL1;
                        lpps_pkg::USED_ONE: n_state = lpps_pkg::S_ATAN1;
                        default:            n_state = lpps_pkg::S_FIN;
                    endcase
                end
            end
            lpps_pkg::S_MUL1:  n_state = lpps_pkg::S_MUL2;
            lpps_pkg::S_MUL2:  n_state = lpps_pkg::S_PREP;
            lpps_pkg::S_PREP:  n_state = lpps_pkg::S_DIV;
            lpps_pkg::S_DIV: begin
                if (32'(r_cnt) == lpps_pkg::DIV_STEPS-1) n_state = lpps_pkg::S_ATAN1;
            end
            lpps_pkg::S_ATAN1: if (c_done) n_state = lpps_pkg::S_SIN;
            lpps_pkg::S_SIN:   if (c_done) n_state = lpps_pkg::S_SCALE;
            lpps_pkg::S_SCALE: n_state = lpps_pkg::S_ATAN2;
            lpps_pkg::S_ATAN2: if (c_done) n_state = lpps_pkg::S_GAIN;
            lpps_pkg::S_GAIN:  n_state = lpps_pkg::S_ROUND;
            lpps_pkg::S_ROUND: n_state = lpps_pkg::S_CORR;
            lpps_pkg::S_CORR:  n_state = lpps_pkg::S_FIN;
            lpps_pkg::S_FIN:   if (out_free) n_state = lpps_pkg::S_IDLE;
            default:           n_state = lpps_pkg::S_IDLE;
        endcase
    end

    // control outputs and CORDIC operands
    always_comb begin
        o_task_pop = (r_state == lpps_pkg::S_IDLE) && !i_task_empty;
        cmd.start  = r_launch;
        cmd.rotate = (r_state == lpps_pkg::S_SIN);
        c_x = lpps_pkg::ONE_Q30;
        c_y = '0;
        c_z = '0;
        unique case (r_state)
            lpps_pkg::S_ATAN1: c_y = $signed({{(CW-16){r_w[15]}}, r_w}) <<< 18;
            lpps_pkg::S_SIN: begin
                c_x = lpps_pkg::KINV_Q30;
                c_z = r_alpha;
            end
            lpps_pkg::S_ATAN2: c_y = r_y1;
            default: ;
        endcase
    end

    // datapath helpers
    always_comb begin
        prod_r  = 31'(r_task.slope_r * $signed({1'b0, r_task.cnt_r}));
        // round half away from zero: (2|num| + den) / (2 den)
        acc_mag = r_acc[30] ? 31'(-r_acc) : 31'(r_acc);
        div_n   = {acc_mag[29:0], 1'b0} + 31'(r_den2[15:1]);
        trial   = {r_rem, r_lo[15]};
        quot    = {r_lo[14:0], trial >= r_den2};
        prod_s  = 50'(r_s * $signed({1'b0, i_ratio}));
        p_sh    = r_p >>> 30;
        corr    = $signed({{(CW-16){r_steer[15]}}, r_steer});
        if (r_task.used == lpps_pkg::USED_TWO) begin
            if (lpps_pkg::mag16(r_steer) < 17'(i_gate2)) begin
                if (r_task.near_r) corr = corr + CW'(i_micro);
                if (r_task.near_l) corr = corr - CW'(i_micro);
            end
        end else if (r_task.near_l && lpps_pkg::mag16(r_last) < 17'(i_gate1)) begin
            corr = r_task.neg_b ? corr + CW'(i_micro) : corr - CW'(i_micro);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lpps_pkg::S_IDLE: begin
                r_task <= i_task;
                r_w    <= i_task.slope_l;
                r_steer <= r_last;
            end
            lpps_pkg::S_MUL1:
                r_acc <= 31'(r_task.slope_l * $signed({1'b0, r_task.cnt_l}));
            lpps_pkg::S_MUL2: begin
                r_acc  <= r_acc + prod_r;
                r_den2 <= {1'b0, 14'(r_task.cnt_l) + 14'(r_task.cnt_r), 1'b0};
            end
            lpps_pkg::S_PREP: begin
                // the quotient fits 16 bits, so seed the remainder with the high bits
                r_neg <= r_acc[30];
                r_rem <= div_n[30:16];
                r_lo  <= div_n[15:0];
                r_cnt <= '0;
            end
            lpps_pkg::S_DIV: begin
                // long division, one quotient bit per cycle
                if (trial >= r_den2) r_rem <= 15'(trial - r_den2);
                else                 r_rem <= trial[14:0];
                r_lo  <= quot;
                r_cnt <= r_cnt + 1'b1;
                if (32'(r_cnt) == lpps_pkg::DIV_STEPS-1)
                    r_w <= r_neg ? 16'(-quot) : quot;
            end
            lpps_pkg::S_ATAN1: if (c_done) r_alpha <= c_oz;
            lpps_pkg::S_SIN:   if (c_done) r_s <= c_oy[33:0];
            lpps_pkg::S_SCALE: r_y1 <= CW'(prod_s >>> 12);
            lpps_pkg::S_ATAN2: if (c_done) r_beta <= c_oz[32:0];
            lpps_pkg::S_GAIN:
                r_p <= 48'(r_beta * $signed({1'b0, i_gain})) + 48'sd536870912;
            lpps_pkg::S_ROUND: r_steer <= lpps_pkg::sat16(p_sh[CW-1:0]);
            lpps_pkg::S_CORR:  r_steer <= lpps_pkg::sat16(corr);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpps_pkg::S_IDLE;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            r_state  <= n_state;
            r_launch <= (n_state != r_state) && (n_state == lpps_pkg::S_ATAN1 ||
                        n_state == lpps_pkg::S_SIN || n_state == lpps_pkg::S_ATAN2);
            if (i_pop && r_out_valid) r_out_valid <= 1'b0;
            if (r_state == lpps_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
                r_last      <= r_steer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lpps_pkg::S_FIN && out_free) begin
            r_out_steer <= r_steer;
            r_out_used  <= r_task.used;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_steer_angle = r_out_steer;
    assign o_lines_used  = r_out_used;

endmodule

// ===== sv/lane_pure_pursuit_steering.sv =====
// Lane pure pursuit steering, top level: config registers, front end, task queue, back end.
// The back end works on one item at a time: the 16-step divider for two lines, then three
// 16-step CORDIC passes for one or two lines; a result left unpopped stalls it.
// The front end and a 2-entry queue take new items while the back end works.
// Reset (i_rst_n low, synchronous): registers go to defaults, queues empty, held angle zero.
module lane_pure_pursuit_steering #(
    parameter int MAX_POINTS   = lpps_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = lpps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_valid_a,
    input  logic signed [15:0]            i_slope_a,
    input  logic signed [15:0]            i_intercept_a,
    input  logic [lpps_pkg::CNT_W-1:0]    i_points_a,
    input  logic                          i_valid_b,
    input  logic signed [15:0]            i_slope_b,
    input  logic signed [15:0]            i_intercept_b,
    input  logic [lpps_pkg::CNT_W-1:0]    i_points_b,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [15:0]            o_steer_angle,
    output logic [1:0]                    o_lines_used,
    input  logic                          i_cfg_we,
    input  logic [lpps_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [lpps_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int LW = $clog2(lpps_pkg::QUEUE_DEPTH+1);

    logic [lpps_pkg::CFG_W-1:0] r_centered, r_micro, r_gate2, r_gate1, r_ratio, r_gain;
    lpps_pkg::t_task front_task, q_task;
    logic            q_empty, q_pop;
    logic [LW-1:0]   q_level;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centered <= 15'd1638;
            r_micro    <= 15'd410;
            r_gate2    <= 15'd1024;
            r_gate1    <= 15'd1229;
            r_ratio    <= 15'd4049;
            r_gain     <= 15'd4915;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpps_pkg::REG_CENTERED: r_centered <= i_cfg_data;
                lpps_pkg::REG_MICRO:    r_micro    <= i_cfg_data;
                lpps_pkg::REG_GATE2:    r_gate2    <= i_cfg_data;
                lpps_pkg::REG_GATE1:    r_gate1    <= i_cfg_data;
                lpps_pkg::REG_RATIO:    r_ratio    <= i_cfg_data;
                lpps_pkg::REG_GAIN:     r_gain     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify the item as it arrives
    lpps_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_valid_a     (i_valid_a),
        .i_slope_a     (i_slope_a),
        .i_intercept_a (i_intercept_a),
        .i_points_a    (i_points_a),
        .i_valid_b     (i_valid_b),
        .i_slope_b     (i_slope_b),
        .i_intercept_b (i_intercept_b),
        .i_points_b    (i_points_b),
        .i_centered    (r_centered),
        .o_task        (front_task)
    );

    // hold classified items until the back end is free
    lpps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_task),
        .i_pop   (q_pop),
        .o_data  (q_task),
        .o_full  (full),
        .o_empty (q_empty),
        .o_level (q_level)
    );

    // compute the angle and present it until popped
    lpps_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_task        (q_task),
        .i_task_empty  (q_empty),
        .o_task_pop    (q_pop),
        .i_micro       (r_micro),
        .i_gate2       (r_gate2),
        .i_gate1       (r_gate1),
        .i_ratio       (r_ratio),
        .i_gain        (r_gain),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_steer_angle (o_steer_angle),
        .o_lines_used  (o_lines_used)
    );

    a_used_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_lines_used != 2'd3)
        else $error("invalid lines_used code on result port");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(q_level) <= lpps_pkg::QUEUE_DEPTH)
        else $error("task queue level beyond depth");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present right after reset");

endmodule
